// ----- design/vertex_affine_transform_assert.svh -----
// assertion macros for the vertex affine transform pipeline
// expects clk and arst_n in the scope of the module that includes it
`ifndef VERTEX_AFFINE_TRANSFORM_ASSERT_SVH
`define VERTEX_AFFINE_TRANSFORM_ASSERT_SVH

// same-cycle implication, off while in reset
`define VAT_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vertex_affine_transform: same-cycle check failed");

// next-cycle implication, off while in reset
`define VAT_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vertex_affine_transform: next-cycle check failed");

`endif

// ----- design/vat_pkg.sv -----
// shared types and constants for the vertex affine transform
// no dependencies; used by vat_cfg, vat_lane and the top level
package vat_pkg;

	localparam int COORD_W       = 32;
	localparam int COEF_W        = 16;
	localparam int COEF_PROD_W   = 2 * COEF_W + 1;       // holds lx^2-ly^2, 2*lx*ly, -coef
	localparam int PROD_W        = COEF_PROD_W + COORD_W;
	localparam int SUM_W         = PROD_W + 1;
	localparam int CFG_IDX_W     = 3;

	localparam int COORD_FRAC_DEF = 16;
	localparam int COEF_FRAC_DEF  = 12;

	typedef enum logic [2:0] {
		MODE_ROTATE  = 3'd0,
		MODE_SCALE   = 3'd1,
		MODE_SHEAR_H = 3'd2,
		MODE_SHEAR_V = 3'd3,
		MODE_REFLECT = 3'd4,
		MODE_PLACE   = 3'd5
	} mode_t;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_A   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_B   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd4;

	localparam logic signed [COEF_W-1:0] COEF_A_RST = 16'sd4096;
	localparam logic signed [COEF_W-1:0] COEF_B_RST = 16'sd4096;
	localparam logic signed [COEF_PROD_W-1:0] REFL_M_RST = COEF_PROD_W'(
		COEF_A_RST * COEF_A_RST - COEF_B_RST * COEF_B_RST);
	localparam logic signed [COEF_PROD_W-1:0] REFL_P_RST = COEF_PROD_W'(
		2 * COEF_A_RST * COEF_B_RST);

	// which rounding shift a lane applies
	typedef enum logic [1:0] {
		SH_SEL_COEF   = 2'd0,
		SH_SEL_DOUBLE = 2'd1,
		SH_SEL_PLACE  = 2'd2
	} shift_sel_t;

	typedef struct packed {
		mode_t                          mode;
		logic signed [COEF_W-1:0]       coef_a;
		logic signed [COEF_W-1:0]       coef_b;
		logic signed [COEF_W-1:0]       offset_x;
		logic signed [COEF_W-1:0]       offset_y;
		logic signed [COEF_PROD_W-1:0]  refl_m;
		logic signed [COEF_PROD_W-1:0]  refl_p;
	} cfg_t;

	typedef struct packed {
		logic signed [COEF_PROD_W-1:0]  cx;
		logic signed [COEF_PROD_W-1:0]  cy;
		shift_sel_t                     sh;
		logic signed [COEF_W-1:0]       off;
	} lane_op_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} lane_en_t;

endpackage

// ----- design/vat_cfg.sv -----
// configuration registers and reflection coefficient precompute
// depends on vat_pkg
module vat_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [vat_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vat_pkg::COEF_W-1:0]         cfg_data,
	output vat_pkg::cfg_t                      cfg
);

	vat_pkg::mode_t                                 mode_q;
	logic signed [vat_pkg::COEF_W-1:0]              coef_a_q;
	logic signed [vat_pkg::COEF_W-1:0]              coef_b_q;
	logic signed [vat_pkg::COEF_W-1:0]              offset_x_q;
	logic signed [vat_pkg::COEF_W-1:0]              offset_y_q;
	logic signed [vat_pkg::COEF_PROD_W-1:0]         refl_m_q;
	logic signed [vat_pkg::COEF_PROD_W-1:0]         refl_p_q;

	logic signed [2*vat_pkg::COEF_W-1:0]            aa;
	logic signed [2*vat_pkg::COEF_W-1:0]            bb;
	logic signed [2*vat_pkg::COEF_W-1:0]            ab;
	logic signed [vat_pkg::COEF_PROD_W-1:0]         refl_m_next;
	logic signed [vat_pkg::COEF_PROD_W-1:0]         refl_p_next;

	// m = lx^2 - ly^2, p = 2*lx*ly, registered from the coefficient registers in the cycle after them
	always_comb begin
		aa          = coef_a_q * coef_a_q;
		bb          = coef_b_q * coef_b_q;
		ab          = coef_a_q * coef_b_q;
		refl_m_next = vat_pkg::COEF_PROD_W'(aa) - vat_pkg::COEF_PROD_W'(bb);
		refl_p_next = vat_pkg::COEF_PROD_W'(ab) <<< 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= vat_pkg::MODE_SCALE;
			coef_a_q   <= vat_pkg::COEF_A_RST;
			coef_b_q   <= vat_pkg::COEF_B_RST;
			offset_x_q <= '0;
			offset_y_q <= '0;
			refl_m_q   <= vat_pkg::REFL_M_RST;
			refl_p_q   <= vat_pkg::REFL_P_RST;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					vat_pkg::CFG_MODE:     mode_q     <= vat_pkg::mode_t'(cfg_data[2:0]);
					vat_pkg::CFG_COEF_A:   coef_a_q   <= cfg_data;
					vat_pkg::CFG_COEF_B:   coef_b_q   <= cfg_data;
					vat_pkg::CFG_OFFSET_X: offset_x_q <= cfg_data;
					vat_pkg::CFG_OFFSET_Y: offset_y_q <= cfg_data;
					default: ;
				endcase
			end
			refl_m_q <= refl_m_next;
			refl_p_q <= refl_p_next;
		end
	end

	always_comb begin
		cfg.mode     = mode_q;
		cfg.coef_a   = coef_a_q;
		cfg.coef_b   = coef_b_q;
		cfg.offset_x = offset_x_q;
		cfg.offset_y = offset_y_q;
		cfg.refl_m   = refl_m_q;
		cfg.refl_p   = refl_p_q;
	end

endmodule

// ----- design/vat_lane.sv -----
// one coordinate lane: two products, sum, round half away from zero,
// offset and clamp to 32 bits over stages s2..s6; depends on vat_pkg
module vat_lane #(
	parameter int COORD_FRAC_BITS = vat_pkg::COORD_FRAC_DEF,
	parameter int COEF_FRAC_BITS  = vat_pkg::COEF_FRAC_DEF
) (
	input  logic                                 clk,
	input  vat_pkg::lane_en_t                    en,
	input  vat_pkg::lane_op_t                    op,
	input  logic signed [vat_pkg::COORD_W-1:0]   coord_x,
	input  logic signed [vat_pkg::COORD_W-1:0]   coord_y,
	output logic signed [vat_pkg::COORD_W-1:0]   result,
	output logic                                 sat
);

	localparam int SW   = vat_pkg::SUM_W;
	localparam int SH_C = COEF_FRAC_BITS;
	localparam int SH_D = 2 * COEF_FRAC_BITS;
	localparam int SH_P = COORD_FRAC_BITS + COEF_FRAC_BITS;

	localparam logic signed [SW-1:0] BIAS_C  = SW'(1) <<< (SH_C - 1);
	localparam logic signed [SW-1:0] BIAS_D  = SW'(1) <<< (SH_D - 1);
	localparam logic signed [SW-1:0] BIAS_P  = SW'(1) <<< (SH_P - 1);
	localparam logic signed [SW-1:0] RES_MAX = (SW'(1) <<< (vat_pkg::COORD_W - 1)) - SW'(1);
	localparam logic signed [SW-1:0] RES_MIN = -(SW'(1) <<< (vat_pkg::COORD_W - 1));

	logic signed [vat_pkg::COEF_PROD_W-1:0]  cx_s2;
	logic signed [vat_pkg::COEF_PROD_W-1:0]  cy_s2;
	logic signed [vat_pkg::COORD_W-1:0]      x_s2;
	logic signed [vat_pkg::COORD_W-1:0]      y_s2;
	vat_pkg::shift_sel_t                     sh_s2;
	logic signed [vat_pkg::COEF_W-1:0]       off_s2;

	logic signed [vat_pkg::PROD_W-1:0]       px_s3;
	logic signed [vat_pkg::PROD_W-1:0]       py_s3;
	vat_pkg::shift_sel_t                     sh_s3;
	logic signed [vat_pkg::COEF_W-1:0]       off_s3;

	logic signed [SW-1:0]                    sum_s4;
	vat_pkg::shift_sel_t                     sh_s4;
	logic signed [vat_pkg::COEF_W-1:0]       off_s4;

	logic signed [SW-1:0]                    rnd_s5;
	logic signed [vat_pkg::COEF_W-1:0]       off_s5;

	logic signed [vat_pkg::COORD_W-1:0]      res_s6;
	logic                                    sat_s6;

	logic signed [SW-1:0]                    bias;
	logic signed [SW-1:0]                    biased;
	logic signed [SW-1:0]                    rounded;
	logic signed [SW-1:0]                    total;
	logic signed [vat_pkg::COORD_W-1:0]      res_next;
	logic                                    sat_next;

	// ties away from zero: negative sums take one less bias before the floor shift
	always_comb begin
		case (sh_s4)
			vat_pkg::SH_SEL_DOUBLE: bias = BIAS_D;
			vat_pkg::SH_SEL_PLACE:  bias = BIAS_P;
			default:                bias = BIAS_C;
		endcase
		biased = sum_s4 + bias - SW'(sum_s4[SW-1]);
		case (sh_s4)
			vat_pkg::SH_SEL_DOUBLE: rounded = biased >>> SH_D;
			vat_pkg::SH_SEL_PLACE:  rounded = biased >>> SH_P;
			default:                rounded = biased >>> SH_C;
		endcase
	end

	always_comb begin
		total = rnd_s5 + SW'(off_s5);
		if (total > RES_MAX) begin
			res_next = RES_MAX[vat_pkg::COORD_W-1:0];
			sat_next = 1'b1;
		end else if (total < RES_MIN) begin
			res_next = RES_MIN[vat_pkg::COORD_W-1:0];
			sat_next = 1'b1;
		end else begin
			res_next = total[vat_pkg::COORD_W-1:0];
			sat_next = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			cx_s2  <= op.cx;
			cy_s2  <= op.cy;
			x_s2   <= coord_x;
			y_s2   <= coord_y;
			sh_s2  <= op.sh;
			off_s2 <= op.off;
		end
		if (en.s3) begin
			px_s3  <= cx_s2 * x_s2;
			py_s3  <= cy_s2 * y_s2;
			sh_s3  <= sh_s2;
			off_s3 <= off_s2;
		end
		if (en.s4) begin
			sum_s4 <= SW'(px_s3) + SW'(py_s3);
			sh_s4  <= sh_s3;
			off_s4 <= off_s3;
		end
		if (en.s5) begin
			rnd_s5 <= rounded;
			off_s5 <= off_s4;
		end
		if (en.s6) begin
			res_s6 <= res_next;
			sat_s6 <= sat_next;
		end
	end

	assign result = res_s6;
	assign sat    = sat_s6;

endmodule

// ----- design/vertex_affine_transform.sv -----
// Vertex affine transform: a six-stage pipeline that takes one Q16.16 vertex per clock
// unless stalled and passes it through its stages in order (input register, coefficient
// select, two multipliers per coordinate, sum, rounding shift, offset and clamp into the
// output register). Each stage holds its item until the next stage has room, so a stalled
// output only blocks the input once all six stages are full; in_ready follows out_ready
// combinationally through that chain. Configuration writes are always taken; the
// reflection terms lx^2-ly^2 and 2*lx*ly are registered in the cycle after a coefficient
// write, which the input register stage covers. No reset-time clearing pass is needed.
// Depends on vat_pkg, vat_cfg, vat_lane and vertex_affine_transform_assert.svh.
`include "vertex_affine_transform_assert.svh"

module vertex_affine_transform #(
	parameter int COORD_FRAC_BITS = vat_pkg::COORD_FRAC_DEF,
	parameter int COEF_FRAC_BITS  = vat_pkg::COEF_FRAC_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [vat_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [vat_pkg::COEF_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [vat_pkg::COORD_W-1:0]   vertex_x,
	input  logic signed [vat_pkg::COORD_W-1:0]   vertex_y,
	input  logic                                 last_vertex,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [vat_pkg::COORD_W-1:0]   out_x,
	output logic signed [vat_pkg::COORD_W-1:0]   out_y,
	output logic                                 out_last,
	output logic                                 saturated
);

	localparam int CW = vat_pkg::COEF_PROD_W;
	localparam logic signed [CW-1:0] COEF_ONE = CW'(1) <<< COEF_FRAC_BITS;

	vat_pkg::cfg_t       cfg;
	vat_pkg::lane_op_t   op_x;
	vat_pkg::lane_op_t   op_y;
	vat_pkg::lane_en_t   lane_en;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;
	logic last_s1, last_s2, last_s3, last_s4, last_s5, last_s6;
	logic signed [vat_pkg::COORD_W-1:0] x_s1;
	logic signed [vat_pkg::COORD_W-1:0] y_s1;
	logic signed [CW-1:0] ca;
	logic signed [CW-1:0] cb;
	logic sat_x, sat_y;

	vat_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign cfg_ready = 1'b1;

	// a stage may load when it is empty or the stage after it loads
	always_comb begin
		en_s6 = !vld_s6 || out_ready;
		en_s5 = !vld_s5 || en_s6;
		en_s4 = !vld_s4 || en_s5;
		en_s3 = !vld_s3 || en_s4;
		en_s2 = !vld_s2 || en_s3;
		en_s1 = !vld_s1 || en_s2;
		lane_en.s2 = en_s2;
		lane_en.s3 = en_s3;
		lane_en.s4 = en_s4;
		lane_en.s5 = en_s5;
		lane_en.s6 = en_s6;
	end

	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			x_s1    <= vertex_x;
			y_s1    <= vertex_y;
			last_s1 <= last_vertex;
		end
		if (en_s2) last_s2 <= last_s1;
		if (en_s3) last_s3 <= last_s2;
		if (en_s4) last_s4 <= last_s3;
		if (en_s5) last_s5 <= last_s4;
		if (en_s6) last_s6 <= last_s5;
	end

	// each lane forms cx*x + cy*y; passthrough coordinates use the unit coefficient
	always_comb begin
		ca = CW'(cfg.coef_a);
		cb = CW'(cfg.coef_b);
		op_x.cx  = COEF_ONE;
		op_x.cy  = '0;
		op_x.sh  = vat_pkg::SH_SEL_COEF;
		op_x.off = '0;
		op_y.cx  = '0;
		op_y.cy  = COEF_ONE;
		op_y.sh  = vat_pkg::SH_SEL_COEF;
		op_y.off = '0;
		case (cfg.mode)
			vat_pkg::MODE_ROTATE: begin
				op_x.cx = ca;
				op_x.cy = -cb;
				op_y.cx = cb;
				op_y.cy = ca;
			end
			vat_pkg::MODE_SCALE: begin
				op_x.cx = ca;
				op_y.cy = cb;
			end
			vat_pkg::MODE_SHEAR_H: begin
				op_x.cy = ca;
			end
			vat_pkg::MODE_SHEAR_V: begin
				op_y.cx = ca;
			end
			vat_pkg::MODE_REFLECT: begin
				op_x.cx = cfg.refl_m;
				op_x.cy = cfg.refl_p;
				op_x.sh = vat_pkg::SH_SEL_DOUBLE;
				op_y.cx = cfg.refl_p;
				op_y.cy = -cfg.refl_m;
				op_y.sh = vat_pkg::SH_SEL_DOUBLE;
			end
			vat_pkg::MODE_PLACE: begin
				op_x.cx  = ca;
				op_x.sh  = vat_pkg::SH_SEL_PLACE;
				op_x.off = cfg.offset_x;
				op_y.cy  = ca;
				op_y.sh  = vat_pkg::SH_SEL_PLACE;
				op_y.off = cfg.offset_y;
			end
			default: ;
		endcase
	end

	vat_lane #(
		.COORD_FRAC_BITS (COORD_FRAC_BITS),
		.COEF_FRAC_BITS  (COEF_FRAC_BITS)
	) u_lane_x (
		.clk     (clk),
		.en      (lane_en),
		.op      (op_x),
		.coord_x (x_s1),
		.coord_y (y_s1),
		.result  (out_x),
		.sat     (sat_x)
	);

	vat_lane #(
		.COORD_FRAC_BITS (COORD_FRAC_BITS),
		.COEF_FRAC_BITS  (COEF_FRAC_BITS)
	) u_lane_y (
		.clk     (clk),
		.en      (lane_en),
		.op      (op_y),
		.coord_x (x_s1),
		.coord_y (y_s1),
		.result  (out_y),
		.sat     (sat_y)
	);

	assign out_valid = vld_s6;
	assign out_last  = last_s6;
	assign saturated = sat_x || sat_y;

	// input backs up only when every stage holds an item and the output is stalled
	`VAT_ASSERT_IMP(a_stall_only_when_full, !in_ready, vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6 && !out_ready)
	// an accepted item is in the input stage next cycle
	`VAT_ASSERT_NXT(a_accept_fills_s1, in_valid && in_ready, vld_s1)
	// the output stage empties only through a taken item
	`VAT_ASSERT_IMP(a_out_drains_on_take, $fell(out_valid), $past(out_ready))

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for vertex_affine_transform: drives vertices and register
// writes, predicts every transformed vertex and compares it field by field
// depends on vat_pkg and the vertex_affine_transform rtl
module tb;

	typedef logic signed [79:0] wide_t;

	typedef struct packed {
		logic signed [vat_pkg::COORD_W-1:0] x;
		logic signed [vat_pkg::COORD_W-1:0] y;
		logic                               end_poly;
	} vertex_t;

	typedef struct packed {
		logic signed [vat_pkg::COORD_W-1:0] x;
		logic signed [vat_pkg::COORD_W-1:0] y;
		logic                               end_poly;
		logic                               clipped;
	} xform_t;

	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_CYCLES  = 300;
	localparam int MAX_REPORTS  = 10;
	localparam logic [2:0] MODE_SPARE_LO = 3'd6;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;
	localparam wide_t COORD_TOP = wide_t'(64'sh7FFF_FFFF);
	localparam wide_t COORD_BOT = -(wide_t'(64'sh8000_0000));

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 cfg_valid = 1'b0;
	logic                                 cfg_ready;
	logic [vat_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
	logic [vat_pkg::COEF_W-1:0]           cfg_data = '0;
	logic                                 in_valid = 1'b0;
	logic                                 in_ready;
	logic signed [vat_pkg::COORD_W-1:0]   vertex_x = '0;
	logic signed [vat_pkg::COORD_W-1:0]   vertex_y = '0;
	logic                                 last_vertex = 1'b0;
	logic                                 out_valid;
	logic                                 out_ready = 1'b0;
	logic signed [vat_pkg::COORD_W-1:0]   out_x;
	logic signed [vat_pkg::COORD_W-1:0]   out_y;
	logic                                 out_last;
	logic                                 saturated;

	// register copies used for prediction
	logic [2:0]                           cur_mode = 3'(vat_pkg::MODE_SCALE);
	logic signed [vat_pkg::COEF_W-1:0]    cur_coef_a = vat_pkg::COEF_A_RST;
	logic signed [vat_pkg::COEF_W-1:0]    cur_coef_b = vat_pkg::COEF_B_RST;
	logic signed [vat_pkg::COEF_W-1:0]    cur_off_x = '0;
	logic signed [vat_pkg::COEF_W-1:0]    cur_off_y = '0;

	vertex_t  vertex_queue[$];
	xform_t   xform_expected[$];
	vertex_t  nxt;
	xform_t   want;
	int       mismatches = 0;
	int       tx_gap = 0;
	int       rx_stall = 0;
	int       hold_left = 0;
	bit       hold_req = 1'b0;
	bit       hold_ack = 1'b0;
	bit       quiet_tx = 1'b0;
	bit       calm = 1'b0;

	vertex_affine_transform dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.vertex_x(vertex_x),
		.vertex_y(vertex_y),
		.last_vertex(last_vertex),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_x(out_x),
		.out_y(out_y),
		.out_last(out_last),
		.saturated(saturated)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// nearest, ties away from zero
	function automatic wide_t round_half_away(wide_t v, int s);
		wide_t mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + (wide_t'(1) <<< (s - 1))) >>> s;
		return (v < 0) ? -mag : mag;
	endfunction

	function automatic xform_t transform_vertex(vertex_t v);
		wide_t x, y, a, b, m, p, rx, ry;
		xform_t r;
		x = v.x;
		y = v.y;
		a = cur_coef_a;
		b = cur_coef_b;
		rx = x;
		ry = y;
		case (cur_mode)
			vat_pkg::MODE_ROTATE: begin
				rx = round_half_away(a * x - b * y, vat_pkg::COEF_FRAC_DEF);
				ry = round_half_away(b * x + a * y, vat_pkg::COEF_FRAC_DEF);
			end
			vat_pkg::MODE_SCALE: begin
				rx = round_half_away(a * x, vat_pkg::COEF_FRAC_DEF);
				ry = round_half_away(b * y, vat_pkg::COEF_FRAC_DEF);
			end
			vat_pkg::MODE_SHEAR_H:
				rx = round_half_away((x <<< vat_pkg::COEF_FRAC_DEF) + a * y,
					vat_pkg::COEF_FRAC_DEF);
			vat_pkg::MODE_SHEAR_V:
				ry = round_half_away((y <<< vat_pkg::COEF_FRAC_DEF) + a * x,
					vat_pkg::COEF_FRAC_DEF);
			vat_pkg::MODE_REFLECT: begin
				m = a * a - b * b;
				p = (a * b) <<< 1;
				rx = round_half_away(m * x + p * y, 2 * vat_pkg::COEF_FRAC_DEF);
				ry = round_half_away(p * x - m * y, 2 * vat_pkg::COEF_FRAC_DEF);
			end
			vat_pkg::MODE_PLACE: begin
				rx = wide_t'(cur_off_x) + round_half_away(a * x,
					vat_pkg::COORD_FRAC_DEF + vat_pkg::COEF_FRAC_DEF);
				ry = wide_t'(cur_off_y) + round_half_away(a * y,
					vat_pkg::COORD_FRAC_DEF + vat_pkg::COEF_FRAC_DEF);
			end
			default: ;
		endcase
		r.clipped = 1'b0;
		if (rx > COORD_TOP) begin
			rx = COORD_TOP;
			r.clipped = 1'b1;
		end else if (rx < COORD_BOT) begin
			rx = COORD_BOT;
			r.clipped = 1'b1;
		end
		if (ry > COORD_TOP) begin
			ry = COORD_TOP;
			r.clipped = 1'b1;
		end else if (ry < COORD_BOT) begin
			ry = COORD_BOT;
			r.clipped = 1'b1;
		end
		r.x = rx[vat_pkg::COORD_W-1:0];
		r.y = ry[vat_pkg::COORD_W-1:0];
		r.end_poly = v.end_poly;
		return r;
	endfunction

	task automatic flag_mismatch(string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// input side: predict on acceptance, then present the next item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				xform_expected.push_back(transform_vertex('{vertex_x, vertex_y, last_vertex}));
			if (in_valid && !in_ready) begin
				// hold the item until taken
			end else if (tx_gap != 0 && !calm) begin
				in_valid <= 1'b0;
				tx_gap <= tx_gap - 1;
			end else if (vertex_queue.size() != 0) begin
				nxt = vertex_queue.pop_front();
				vertex_x <= nxt.x;
				vertex_y <= nxt.y;
				last_vertex <= nxt.end_poly;
				in_valid <= 1'b1;
				if (!calm && !quiet_tx && $urandom_range(0, 15) == 0)
					tx_gap <= $urandom_range(1, 18);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side: check each taken result, then choose ready for the next cycle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_stall <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (xform_expected.size() == 0) begin
					flag_mismatch($sformatf("unexpected vertex x=%0d y=%0d last=%0b sat=%0b",
						out_x, out_y, out_last, saturated));
				end else begin
					want = xform_expected.pop_front();
					if (out_x !== want.x || out_y !== want.y || out_last !== want.end_poly
							|| saturated !== want.clipped)
						flag_mismatch($sformatf(
							"expected x=%0d y=%0d last=%0b sat=%0b, got x=%0d y=%0d last=%0b sat=%0b",
							want.x, want.y, want.end_poly, want.clipped,
							out_x, out_y, out_last, saturated));
				end
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
			end else if (rx_stall != 0 && !calm) begin
				out_ready <= 1'b0;
				rx_stall <= rx_stall - 1;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 15) == 0)
					rx_stall <= $urandom_range(1, 18);
			end
		end
	end

	// long receiver hold-off, started by toggling hold_req
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_ack <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_ack) begin
			hold_left <= HOLD_CYCLES;
			hold_ack <= hold_req;
		end
	end

	task automatic add_vertex(logic [vat_pkg::COORD_W-1:0] x, logic [vat_pkg::COORD_W-1:0] y,
			logic e);
		vertex_queue.push_back(vertex_t'{x, y, e});
	endtask

	// called at a rising edge; returns at the edge that took the write
	task automatic write_reg(logic [vat_pkg::CFG_IDX_W-1:0] idx,
			logic [vat_pkg::COEF_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			vat_pkg::CFG_MODE:     cur_mode = data[2:0];
			vat_pkg::CFG_COEF_A:   cur_coef_a = data;
			vat_pkg::CFG_COEF_B:   cur_coef_b = data;
			vat_pkg::CFG_OFFSET_X: cur_off_x = data;
			vat_pkg::CFG_OFFSET_Y: cur_off_y = data;
			default: ;
		endcase
	endtask

	task automatic load_config(logic [2:0] mode, logic [vat_pkg::COEF_W-1:0] a,
			logic [vat_pkg::COEF_W-1:0] b, logic [vat_pkg::COEF_W-1:0] ox,
			logic [vat_pkg::COEF_W-1:0] oy);
		// upper data bits of a mode write carry junk
		write_reg(vat_pkg::CFG_MODE, {13'($urandom), mode});
		write_reg(vat_pkg::CFG_COEF_A, a);
		write_reg(vat_pkg::CFG_COEF_B, b);
		write_reg(vat_pkg::CFG_OFFSET_X, ox);
		write_reg(vat_pkg::CFG_OFFSET_Y, oy);
		if ($urandom_range(0, 3) == 0)
			write_reg(vat_pkg::CFG_OFFSET_Y + 3'($urandom_range(1, 3)), 16'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (vertex_queue.size() != 0 || in_valid || xform_expected.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [vat_pkg::COORD_W-1:0] pick_coord();
		logic [vat_pkg::COORD_W-1:0] r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($urandom_range(0, 2)) - 32'd1;
			3: return (r & 32'hFFFF_F000) | 32'h0000_0800;
			4: return (r & 32'hFFFF_0000) | 32'h0000_8000;
			5, 6: return r;
			default: return {{11{r[20]}}, r[20:0]};
		endcase
	endfunction

	function automatic logic [vat_pkg::COEF_W-1:0] pick_coef();
		logic [vat_pkg::COEF_W-1:0] r;
		r = $urandom;
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return vat_pkg::COEF_A_RST;
			3: return -vat_pkg::COEF_A_RST;
			4, 5: return r;
			default: return {{3{r[12]}}, r[12:0]};
		endcase
	endfunction

	function automatic logic [2:0] pick_mode();
		int m;
		m = $urandom_range(0, 19);
		if (m < 18)
			return 3'(m % 6);
		return (m == 18) ? MODE_SPARE_LO : MODE_SPARE_HI;
	endfunction

	// polygons of 3 to 8 vertices, with a stray last flag now and then
	task automatic push_polygons(int count);
		int left;
		left = 0;
		for (int k = 0; k < count; k++) begin
			if (left == 0)
				left = $urandom_range(3, 8);
			left--;
			add_vertex(pick_coord(), pick_coord(), left == 0 || $urandom_range(0, 31) == 0);
		end
	endtask

	initial begin
		int spins;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings scale by one
		add_vertex(32'h0, 32'h0, 1'b0);
		add_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		wait_drained();

		// half scale: ties go away from zero
		load_config(vat_pkg::MODE_SCALE, 16'h0800, 16'h0800, 16'h0000, 16'h0000);
		add_vertex(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
		add_vertex(32'h0000_0003, 32'hFFFF_FFFD, 1'b0);
		add_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		wait_drained();

		// extreme factors clip both ways
		load_config(vat_pkg::MODE_SCALE, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
		add_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		add_vertex(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
		wait_drained();

		// quarter turn: negating the most negative y overflows
		load_config(vat_pkg::MODE_ROTATE, 16'h0000, 16'h1000, 16'h0000, 16'h0000);
		add_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		add_vertex(32'h0001_0000, 32'h0002_0000, 1'b1);
		wait_drained();

		load_config(vat_pkg::MODE_SHEAR_H, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
		add_vertex(32'h0000_0001, 32'h7FFF_FFFF, 1'b0);
		add_vertex(32'h0000_0007, 32'h0000_0800, 1'b1);
		wait_drained();

		load_config(vat_pkg::MODE_SHEAR_V, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
		add_vertex(32'h8000_0000, 32'h0000_0001, 1'b0);
		add_vertex(32'h0000_0800, 32'hFFFF_FFF9, 1'b1);
		wait_drained();

		// non-unit line: largest 2*lx*ly term
		load_config(vat_pkg::MODE_REFLECT, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
		add_vertex(32'h8000_0000, 32'h8000_0000, 1'b0);
		add_vertex(32'h0001_0000, 32'hFFFF_0000, 1'b1);
		wait_drained();

		// placement: half pixels round away from zero, offsets at their extremes
		load_config(vat_pkg::MODE_PLACE, 16'h1000, 16'h0000, 16'h7FFF, 16'h8000);
		add_vertex(32'h0000_8000, 32'hFFFF_8000, 1'b0);
		add_vertex(32'h0002_8000, 32'hFFFD_8000, 1'b0);
		add_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
		wait_drained();

		// spare modes pass the vertex through
		load_config(MODE_SPARE_LO, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
		add_vertex(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
		wait_drained();
		load_config(MODE_SPARE_HI, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
		add_vertex(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
		wait_drained();

		for (int ph = 0; ph < 24; ph++) begin
			load_config(pick_mode(), pick_coef(), pick_coef(), 16'($urandom), 16'($urandom));
			if (ph == 12) begin
				// receiver goes quiet while the sender keeps pushing
				quiet_tx = 1'b1;
				hold_req = !hold_req;
				push_polygons(90);
			end else begin
				push_polygons($urandom_range(20, 50));
			end
			wait_drained();
			quiet_tx = 1'b0;
		end

		calm = 1'b1;
		load_config(pick_mode(), pick_coef(), pick_coef(), 16'($urandom), 16'($urandom));
		push_polygons(150);

		spins = 0;
		while ((vertex_queue.size() != 0 || in_valid || xform_expected.size() != 0)
				&& spins < 20000) begin
			@(posedge clk);
			spins++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (xform_expected.size() != 0)
			flag_mismatch($sformatf("%0d vertices never came out", xform_expected.size()));

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
